// ----- sv/rational_fraction_alu_macros.svh -----
// Assertion macros for the rational fraction ALU.
`ifndef RATIONAL_FRACTION_ALU_MACROS_SVH
`define RATIONAL_FRACTION_ALU_MACROS_SVH

// Check a property on clk with reset masked.
`define RFA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal holds for the cycle after a condition.
`define RFA_ASSERT_STABLE(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> $stable(sig)) else $error(msg);

`endif

// ----- sv/rfa_pkg.sv -----
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants of the rational fraction ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int OPERAND_BITS_DEFAULT = 32;
    localparam int MAG_BITS             = 64;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] left_num;
        logic signed [31:0] left_den;
        logic signed [31:0] right_num;
        logic signed [31:0] right_den;
    } in_word_t;

    typedef struct packed {
        logic        is_inf;
        logic        is_negative;
        logic [62:0] whole_part;
        logic [61:0] frac_num;
        logic [61:0] frac_den;
    } out_word_t;

endpackage

// ----- sv/rational_fraction_alu.sv -----
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Adds, subtracts, multiplies or divides two signed fractions and returns the
// sign, whole part and gcd-reduced remainder fraction.
// ----------------------------------------------------------------------------
// One word is taken at a time. Products are formed one per cycle on a shared
// multiplier (two products for multiply and divide, three for add and
// subtract), then a shared 64-bit restoring divider produces one quotient bit
// a cycle for whole part and remainder, for each Euclid step (data dependent,
// at most about 92 steps) and for the two final reductions. A zero top or
// bottom product skips the divider. The result sits in an output register;
// the block takes no new word until it has been delivered.
module rational_fraction_alu #(
    parameter int OPERAND_BITS = rfa_pkg::OPERAND_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rfa_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output rfa_pkg::out_word_t out_word
);
    import rfa_pkg::*;

    localparam int CNT_BITS = $clog2(MAG_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CHECK, S_DIV, S_GCD, S_RED_NUM, S_RED_DEN, S_DONE
    } state_t;

    state_t state_reg, state_next;

    // operand magnitudes and signs: 0 ln, 1 ld, 2 rn, 3 rd
    logic [OPERAND_BITS-1:0] mag_reg [4];
    logic [3:0]              neg_reg;
    logic [1:0]              kind_reg;
    logic [2:0]              step_reg, step_next;

    logic [MAG_BITS-1:0] p0_reg, p0_next;   // first top product
    logic                p0n_reg, p0n_next;
    logic [MAG_BITS-1:0] top_reg, top_next;
    logic                topn_reg, topn_next;
    logic [MAG_BITS-1:0] bot_reg, bot_next;
    logic                botn_reg, botn_next;

    // shared divider
    logic [MAG_BITS-1:0] dq_reg, dq_next;     // dividend shifting into quotient
    logic [MAG_BITS:0]   drem_reg, drem_next;
    logic [MAG_BITS-1:0] dsor_reg, dsor_next;
    logic [CNT_BITS-1:0] dcnt_reg, dcnt_next;

    logic [MAG_BITS-1:0] rem_reg, rem_next;
    out_word_t           res_reg, res_next;
    logic                ov_reg, ov_next;

    // sign-magnitude operand decode
    logic [OPERAND_BITS-1:0] fld [4];
    logic [OPERAND_BITS-1:0] fmag [4];
    always_comb
    begin
        fld[0] = in_word.left_num[OPERAND_BITS-1:0];
        fld[1] = in_word.left_den[OPERAND_BITS-1:0];
        fld[2] = in_word.right_num[OPERAND_BITS-1:0];
        fld[3] = in_word.right_den[OPERAND_BITS-1:0];
        for (int i = 0; i < 4; i++)
        begin
            fmag[i] = fld[i][OPERAND_BITS-1] ? (~fld[i] + 1'b1) : fld[i];
        end
    end

    // the most negative value's magnitude is 2^(N-1), which fits N bits
    logic [OPERAND_BITS-1:0] ma, mb;
    logic                    mn;
    logic [MAG_BITS-1:0]     prod;
    always_comb
    begin
        ma = mag_reg[0];
        mb = mag_reg[3];
        mn = neg_reg[0] ^ neg_reg[3];
        case (step_reg)
            3'd0:
            begin
                if (kind_reg == KIND_MUL)
                begin
                    mb = mag_reg[2]; mn = neg_reg[0] ^ neg_reg[2];
                end
            end
            3'd1:
            begin
                ma = mag_reg[2]; mb = mag_reg[1];
                mn = neg_reg[2] ^ neg_reg[1] ^ (kind_reg == KIND_SUB);
            end
            default:
            begin
                ma = mag_reg[1];
                mb = (kind_reg == KIND_DIV) ? mag_reg[2] : mag_reg[3];
                mn = neg_reg[1] ^ ((kind_reg == KIND_DIV) ? neg_reg[2] : neg_reg[3]);
            end
        endcase
        prod = MAG_BITS'(ma) * MAG_BITS'(mb);
    end

    // one restoring division step
    logic [MAG_BITS:0] trial;
    logic [MAG_BITS:0] shifted;
    always_comb
    begin
        shifted = {drem_reg[MAG_BITS-1:0], dq_reg[MAG_BITS-1]};
        trial   = shifted - {1'b0, dsor_reg};
    end

    logic [MAG_BITS-1:0] quo_fin, rem_fin;
    always_comb
    begin
        quo_fin = {dq_reg[MAG_BITS-2:0], ~trial[MAG_BITS]};
        rem_fin = trial[MAG_BITS] ? shifted[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        p0_next = p0_reg; p0n_next = p0n_reg;
        top_next = top_reg; topn_next = topn_reg;
        bot_next = bot_reg; botn_next = botn_reg;
        dq_next = dq_reg; drem_next = drem_reg; dsor_next = dsor_reg; dcnt_next = dcnt_reg;
        rem_next = rem_reg;
        res_next = res_reg;
        ov_next = ov_reg;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                step_next = 3'd0;
                if (in_valid && !ov_reg)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        p0_next = prod; p0n_next = mn;
                        if (kind_reg == KIND_MUL || kind_reg == KIND_DIV)
                        begin
                            top_next = prod; topn_next = mn; step_next = 3'd2;
                        end
                    end
                    3'd1:
                    begin
                        if (p0n_reg == mn)
                        begin
                            top_next = p0_reg + prod; topn_next = mn;
                        end
                        else if (p0_reg >= prod)
                        begin
                            top_next = p0_reg - prod; topn_next = p0n_reg;
                        end
                        else
                        begin
                            top_next = prod - p0_reg; topn_next = mn;
                        end
                    end
                    default:
                    begin
                        bot_next = prod; botn_next = mn;
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_CHECK:
            begin
                res_next = '0;
                if (bot_reg == '0)
                begin
                    res_next.is_inf = 1'b1;
                    state_next = S_DONE;
                end
                else if (top_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    res_next.is_negative = topn_reg ^ botn_reg;
                    dq_next = top_reg; drem_next = '0; dsor_next = bot_reg;
                    dcnt_next = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV, S_GCD, S_RED_NUM, S_RED_DEN:
            begin
                dq_next   = quo_fin;
                drem_next = {1'b0, rem_fin};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == CNT_BITS'(MAG_BITS - 1))
                begin
                    dcnt_next = '0;
                    drem_next = '0;
                    case (state_reg)
                        S_DIV:
                        begin
                            res_next.whole_part = (quo_fin[MAG_BITS-1]) ? '1 : quo_fin[62:0];
                            rem_next = rem_fin;
                            // gcd(bot, rem): x = bot, y = rem
                            if (rem_fin == '0)
                            begin
                                dq_next = '0; dsor_next = bot_reg;
                                state_next = S_RED_NUM;
                            end
                            else
                            begin
                                dq_next = bot_reg; dsor_next = rem_fin;
                                state_next = S_GCD;
                            end
                        end
                        S_GCD:
                        begin
                            // x mod y done; new x = y, new y = remainder
                            if (rem_fin == '0)
                            begin
                                dq_next = rem_reg;
                                state_next = S_RED_NUM;
                            end
                            else
                            begin
                                dq_next = dsor_reg; dsor_next = rem_fin;
                                state_next = S_GCD;
                            end
                        end
                        S_RED_NUM:
                        begin
                            res_next.frac_num = quo_fin[61:0];
                            dq_next = bot_reg;
                            state_next = S_RED_DEN;
                        end
                        default:
                        begin
                            res_next.frac_den = (quo_fin[63:62] != 2'b00) ? '1 : quo_fin[61:0];
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            step_reg  <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            step_reg  <= step_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && !ov_reg)
        begin
            kind_reg <= in_word.kind;
            for (int i = 0; i < 4; i++)
            begin
                mag_reg[i] <= fmag[i];
                neg_reg[i] <= fld[i][OPERAND_BITS-1];
            end
        end
        p0_reg <= p0_next; p0n_reg <= p0n_next;
        top_reg <= top_next; topn_reg <= topn_next;
        bot_reg <= bot_next; botn_reg <= botn_next;
        dq_reg <= dq_next; drem_reg <= drem_next; dsor_reg <= dsor_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_word  = res_reg;

`include "rational_fraction_alu_macros.svh"

    `RFA_ASSERT(a_busy_stall, (state_reg != S_IDLE) |-> in_stall, "busy but not stalled")
    `RFA_ASSERT(a_done_valid, (state_reg == S_DONE) |=> out_valid, "result not shown")
    `RFA_ASSERT(a_inf_clean, (out_valid && out_word.is_inf) |-> (out_word.whole_part == '0),
        "inf carries data")
    `RFA_ASSERT(a_valid_hold, (out_valid && out_stall) |=> out_valid, "stalled word dropped")
    `RFA_ASSERT_STABLE(a_word_hold, out_valid && out_stall, out_word, "stalled word changed")

endmodule

// ----- tb/rational_fraction_alu_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_test
// Drives fraction pairs through the ALU and checks every result word against
// a local sign-magnitude model: a directed table first, then random words,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module rational_fraction_alu_test;

    import rfa_pkg::*;

    localparam int RANDOM_WORDS = 1450;

    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } smag_t;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t result;
    } table_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_word;

    out_word_t pending_results[$];
    int        errors = 0;
    int        cycle_cnt = 0;
    int        stall_left = 0;

    rational_fraction_alu dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always #2 clk = ~clk;

    function automatic smag_t to_smag(logic [31:0] v);
        smag_t r;
        r.neg = v[31];
        r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        return r;
    endfunction

    function automatic smag_t smag_mul(smag_t x, smag_t y);
        smag_t r;
        r.neg = x.neg ^ y.neg;
        r.mag = x.mag * y.mag;
        return r;
    endfunction

    function automatic smag_t smag_add(smag_t x, smag_t y);
        smag_t r;
        if (x.neg == y.neg)
        begin
            r.neg = x.neg;
            r.mag = x.mag + y.mag;
        end
        else if (x.mag >= y.mag)
        begin
            r.neg = x.neg;
            r.mag = x.mag - y.mag;
        end
        else
        begin
            r.neg = y.neg;
            r.mag = y.mag - x.mag;
        end
        return r;
    endfunction

    function automatic out_word_t fraction_result(in_word_t w);
        smag_t       a, b, c, d, top, bot, t;
        logic [63:0] whole, rem, g, x, y, tmp, fd;
        out_word_t   r;
        a = to_smag(w.left_num);
        b = to_smag(w.left_den);
        c = to_smag(w.right_num);
        d = to_smag(w.right_den);
        case (kind_t'(w.kind))
            KIND_ADD:
            begin
                top = smag_add(smag_mul(a, d), smag_mul(c, b));
                bot = smag_mul(b, d);
            end
            KIND_SUB:
            begin
                t = smag_mul(c, b);
                t.neg = !t.neg;
                top = smag_add(smag_mul(a, d), t);
                bot = smag_mul(b, d);
            end
            KIND_MUL:
            begin
                top = smag_mul(a, c);
                bot = smag_mul(b, d);
            end
            default:
            begin
                top = smag_mul(a, d);
                bot = smag_mul(b, c);
            end
        endcase
        r = '0;
        if (bot.mag == 0)
        begin
            r.is_inf = 1'b1;
            return r;
        end
        if (top.mag == 0)
            return r;
        whole = top.mag / bot.mag;
        rem = top.mag % bot.mag;
        x = bot.mag;
        y = rem;
        while (y != 0)
        begin
            tmp = x % y;
            x = y;
            y = tmp;
        end
        g = x;
        rem = rem / g;
        fd = bot.mag / g;
        r.is_negative = top.neg ^ bot.neg;
        r.whole_part = whole[63] ? {63{1'b1}} : whole[62:0];
        r.frac_num = rem[61:0];
        r.frac_den = (fd > 64'h3FFF_FFFF_FFFF_FFFF) ? {62{1'b1}} : fd[61:0];
        return r;
    endfunction

    function automatic in_word_t make_word(logic [1:0] k, int a, int b, int c, int d);
        in_word_t w;
        w.kind = k;
        w.left_num = a;
        w.left_den = b;
        w.right_num = c;
        w.right_den = d;
        return w;
    endfunction

    function automatic out_word_t make_result(bit inf, bit neg, longint wp,
                                              longint fnum, longint fden);
        out_word_t r;
        r.is_inf = inf;
        r.is_negative = neg;
        r.whole_part = 63'(wp);
        r.frac_num = 62'(fnum);
        r.frac_den = 62'(fden);
        return r;
    endfunction

    function automatic logic [31:0] rand_operand(bit is_den);
        int sel;
        sel = $urandom_range(0, 29);
        if (is_den && sel == 0)
            return 32'd0;
        if (sel < 10)
            return 32'($urandom_range(0, 40)) - 32'd20;
        if (sel < 18)
            return $urandom;
        if (sel < 21)
        begin
            case ($urandom_range(0, 5))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h8000_0001;
                3: return 32'd1;
                4: return 32'hFFFF_FFFF;
                default: return 32'd0;
            endcase
        end
        return 32'($urandom_range(0, 2000)) - 32'd1000;
    endfunction

    // Gap before a word: mostly none or short, a few long.
    task automatic send_word(in_word_t w, bit gaps);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (gaps)
            gap = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(20, 100);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(fraction_result(w));
    endtask

    // Output side: quiet stretches alternate with random stalls.
    always @(posedge clk)
    begin
        int r;
        cycle_cnt <= cycle_cnt + 1;
        r = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (cycle_cnt[12] || r < 65)
            out_stall <= 1'b0;
        else if (r < 95)
        begin
            stall_left <= $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left <= $urandom_range(20, 80);
            out_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, out_word);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_word.is_inf !== want.is_inf)
                begin
                    $display("%0t: is_inf expected %b got %b", $time,
                             want.is_inf, out_word.is_inf);
                    errors++;
                end
                if (out_word.is_negative !== want.is_negative)
                begin
                    $display("%0t: is_negative expected %b got %b", $time,
                             want.is_negative, out_word.is_negative);
                    errors++;
                end
                if (out_word.whole_part !== want.whole_part)
                begin
                    $display("%0t: whole_part expected %h got %h", $time,
                             want.whole_part, out_word.whole_part);
                    errors++;
                end
                if (out_word.frac_num !== want.frac_num)
                begin
                    $display("%0t: frac_num expected %h got %h", $time,
                             want.frac_num, out_word.frac_num);
                    errors++;
                end
                if (out_word.frac_den !== want.frac_den)
                begin
                    $display("%0t: frac_den expected %h got %h", $time,
                             want.frac_den, out_word.frac_den);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #(64'd400_000_000);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        table_row_t rows[$];
        in_word_t   w;
        int         i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;

        // 1/2 + 1/3 = 5/6 right after reset
        rows.push_back('{make_word(KIND_ADD, 1, 2, 1, 3), 1, make_result(0, 0, 0, 5, 6)});
        // divide by a zero numerator
        rows.push_back('{make_word(KIND_DIV, 3, 4, 0, 5), 1, make_result(1, 0, 0, 0, 0)});
        // zero over zero is still infinite
        rows.push_back('{make_word(KIND_MUL, 0, 0, 0, 7), 1, make_result(1, 0, 0, 0, 0)});
        // zero numerator
        rows.push_back('{make_word(KIND_MUL, 0, 5, 3, 7), 1, make_result(0, 0, 0, 0, 0)});
        rows.push_back('{make_word(KIND_SUB, 2, 3, 4, 6), 1, make_result(0, 0, 0, 0, 0)});
        rows.push_back('{make_word(KIND_MUL, -1, 2, 1, 3), 1, make_result(0, 1, 0, 1, 6)});
        rows.push_back('{make_word(KIND_ADD, 7, 2, 0, 1), 1, make_result(0, 0, 3, 1, 2)});
        // exact quotient: no remainder
        rows.push_back('{make_word(KIND_MUL, 4, 2, 1, 1), 1, make_result(0, 0, 2, 0, 1)});
        rows.push_back('{make_word(KIND_DIV, -6, 1, 3, -1), 1, make_result(0, 0, 2, 0, 1)});
        rows.push_back('{make_word(KIND_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1), 0, '0});
        rows.push_back('{make_word(KIND_SUB, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1), 0, '0});
        rows.push_back('{make_word(KIND_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1), 0, '0});
        rows.push_back('{make_word(KIND_DIV, 32'h8000_0000, 1, 1, 32'h8000_0000), 0, '0});
        rows.push_back('{make_word(KIND_ADD, 1, 32'h8000_0000, 1, 32'h8000_0000), 0, '0});
        rows.push_back('{make_word(KIND_ADD, 32'h8000_0000, 32'h8000_0000,
                                   32'h8000_0000, 32'h8000_0000), 0, '0});
        rows.push_back('{make_word(KIND_SUB, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE), 0, '0});
        rows.push_back('{make_word(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0001,
                                   32'h8000_0000, 32'h7FFF_FFFF), 0, '0});
        rows.push_back('{make_word(KIND_MUL, -1, -1, -1, -1), 0, '0});
        rows.push_back('{make_word(KIND_DIV, 5, 0, 3, 0), 0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[j])
        begin
            send_word(rows[j].word, 0);
            // a typed row overrides the computed expectation
            if (rows[j].typed)
                pending_results[pending_results.size() - 1] = rows[j].result;
        end

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            w.kind = 2'($urandom_range(0, 3));
            w.left_num = rand_operand(0);
            w.left_den = rand_operand(1);
            w.right_num = rand_operand(w.kind == KIND_DIV);
            w.right_den = rand_operand(1);
            // run back to back in one stretch
            send_word(w, !(i >= 300 && i < 400));
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- rational_fraction_alu.f -----
+incdir+sv
sv/rfa_pkg.sv
sv/rational_fraction_alu.sv
tb/rational_fraction_alu_test.sv
